// File: rtl/tsc_pkg.sv
`default_nettype none

package tsc_pkg;

  localparam int STAMP_W = 36;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam int FRONT_STAGES = 6;
  localparam int BACK_STAGES  = 9;
  localparam int STAGES       = FRONT_STAGES + BACK_STAGES;

  localparam int Z_W   = 21;
  localparam int SOD_W = 17;
  localparam int DOE_W = 18;
  localparam int DOY_W = 9;
  localparam int YOE_W = 9;
  localparam int ERA_W = 3;

  // packed YYYYMMDD window
  localparam logic signed [STAMP_W-1:0] PACK_LO = 36'sd19000101;
  localparam logic signed [STAMP_W-1:0] PACK_HI = 36'sd29991231;

  // 397683 days of seconds: moves every input to a nonnegative count
  localparam logic [STAMP_W:0] SEC_OFF = 37'd34359811200;
  // 719468 - 397683
  localparam logic [Z_W-1:0]   Z_SHIFT = 21'd321785;

  localparam logic [20:0] DAYS_PER_ERA = 21'd146097;

  // ceil(2^S / d) reciprocals, exact over the ranges they see
  localparam logic [30:0] RCP_675   = 31'(((64'd1 << 40) / 64'd675) + 64'd1);
  localparam logic [25:0] RCP_100   = 26'(((64'd1 << 32) / 64'd100) + 64'd1);
  localparam logic [18:0] RCP_100B  = 19'(((64'd1 << 25) / 64'd100) + 64'd1);
  localparam logic [9:0]  RCP_100Y  = 10'(((64'd1 << 16) / 64'd100) + 64'd1);
  localparam logic [21:0] RCP_ERA   = 22'(((64'd1 << 39) / 64'd146097) + 64'd1);
  localparam logic [17:0] RCP_1460  = 18'(((64'd1 << 28) / 64'd1460) + 64'd1);
  localparam logic [17:0] RCP_36524 = 18'(((64'd1 << 33) / 64'd36524) + 64'd1);
  localparam logic [17:0] RCP_365   = 18'(((64'd1 << 26) / 64'd365) + 64'd1);
  localparam logic [11:0] RCP_153   = 12'(((64'd1 << 19) / 64'd153) + 64'd1);
  localparam logic [17:0] RCP_3600  = 18'(((64'd1 << 29) / 64'd3600) + 64'd1);
  localparam logic [12:0] RCP_60    = 13'(((64'd1 << 18) / 64'd60) + 64'd1);

  typedef struct packed {
    logic [Z_W-1:0]   z;
    logic [SOD_W-1:0] sod;
    logic             packed_date;
  } front_t;

  // day of year (from March 1) at which shifted month mp starts
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tsc_in_if.sv
`default_nettype none

interface tsc_in_if;
  import tsc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [STAMP_W-1:0]  stamp_value;

  modport source (output valid, output stamp_value, input ready);
  modport sink (input valid, input stamp_value, output ready);
endinterface

`default_nettype wire

// File: rtl/tsc_out_if.sv
`default_nettype none

interface tsc_out_if;
  import tsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic               packed_date_seen;

  modport source (
    output valid, output year, output month, output day, output hour,
    output minute, output second, output packed_date_seen, input ready
  );
  modport sink (
    input valid, input year, input month, input day, input hour,
    input minute, input second, input packed_date_seen, output ready
  );
endinterface

`default_nettype wire

// File: rtl/tsc_ctrl.sv
`default_nettype none

module tsc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       out_ready,
  output logic                       in_ready,
  output logic                       out_valid,
  output logic [tsc_pkg::STAGES-1:0] en
);
  import tsc_pkg::*;

  logic [STAGES-1:0] valid;

  // a stage loads when some stage at or after it is empty, or the output drains
  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      en[i] = out_ready || ((valid | ((STAGES'(1) << i) - STAGES'(1))) != '1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (valid & ~en) | ({valid[STAGES-2:0], in_valid} & en);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/tsc_front.sv
`default_nettype none

module tsc_front (
  input  logic                               clk,
  input  logic [tsc_pkg::FRONT_STAGES-1:0]   en,
  input  logic signed [tsc_pkg::STAMP_W-1:0] stamp_value,
  output tsc_pkg::front_t                    front
);
  import tsc_pkg::*;

  // stage 1
  logic [STAMP_W:0] s1_u;
  logic             s1_inr;
  logic [24:0]      s1_v;
  logic [18:0]      s1_q100;
  logic [50:0]      q100_prod;

  // stage 2
  logic [19:0]      s2_qs;
  logic [29:0]      s2_q1;
  logic [6:0]       s2_lo;
  logic [6:0]       s2_d;
  logic [11:0]      s2_yv;
  logic [18:0]      s2_q100;
  logic             s2_inr;
  logic [60:0]      qs_prod;
  logic [25:0]      d_diff;
  logic [37:0]      yv_prod;

  // stage 3
  logic [19:0]      s3_qs;
  logic [9:0]       s3_r;
  logic [6:0]       s3_lo;
  logic             s3_packed;
  logic [11:0]      s3_yadj;
  logic [3:0]       s3_mp;
  logic [4:0]       s3_d;
  logic [29:0]      r_diff;
  logic [18:0]      m_diff;
  logic [6:0]       m;

  // stage 4
  logic [Z_W-1:0]   s4_zs;
  logic [SOD_W-1:0] s4_sod;
  logic [ERA_W-1:0] s4_era;
  logic [YOE_W-1:0] s4_yoe;
  logic [DOY_W-1:0] s4_doy;
  logic             s4_packed;
  logic [ERA_W-1:0] era_p;
  logic [11:0]      yoe_diff;

  // stage 5
  logic [Z_W-1:0]   s5_zs;
  logic [SOD_W-1:0] s5_sod;
  logic [ERA_W-1:0] s5_era;
  logic [DOE_W-1:0] s5_doe;
  logic             s5_packed;
  logic [18:0]      yq_prod;

  logic [Z_W-1:0]   zp;

  assign q100_prod = 51'(stamp_value[24:0]) * 51'(RCP_100);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_u    <= {stamp_value[STAMP_W-1], stamp_value} + SEC_OFF;
      s1_inr  <= (stamp_value >= PACK_LO) && (stamp_value <= PACK_HI);
      s1_v    <= stamp_value[24:0];
      s1_q100 <= q100_prod[50:32];
    end
  end

  assign qs_prod = 61'(s1_u[STAMP_W:7]) * 61'(RCP_675);
  assign d_diff  = 26'(s1_v) - (26'(s1_q100) * 26'd100);
  assign yv_prod = 38'(s1_q100) * 38'(RCP_100B);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_qs   <= qs_prod[59:40];
      s2_q1   <= s1_u[STAMP_W:7];
      s2_lo   <= s1_u[6:0];
      s2_d    <= d_diff[6:0];
      s2_yv   <= yv_prod[36:25];
      s2_q100 <= s1_q100;
      s2_inr  <= s1_inr;
    end
  end

  assign r_diff = s2_q1 - (30'(s2_qs) * 30'd675);
  assign m_diff = s2_q100 - (19'(s2_yv) * 19'd100);
  assign m      = m_diff[6:0];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_qs     <= s2_qs;
      s3_r      <= r_diff[9:0];
      s3_lo     <= s2_lo;
      s3_packed <= s2_inr && (m >= 7'd1) && (m <= 7'd12) && (s2_d >= 7'd1) && (s2_d <= 7'd31);
      s3_yadj   <= (m <= 7'd2) ? s2_yv - 12'd1 : s2_yv;
      s3_mp     <= (m > 7'd2) ? 4'(m - 7'd3) : 4'(m + 7'd9);
      s3_d      <= s2_d[4:0];
    end
  end

  // year / 400; the adjusted year lies in 1899..2999
  always_comb begin
    if (s3_yadj >= 12'd2800) begin
      era_p = 3'd7;
    end else if (s3_yadj >= 12'd2400) begin
      era_p = 3'd6;
    end else if (s3_yadj >= 12'd2000) begin
      era_p = 3'd5;
    end else begin
      era_p = 3'd4;
    end
  end

  assign yoe_diff = s3_yadj - (12'(era_p) * 12'd400);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_zs     <= 21'(s3_qs) + Z_SHIFT;
      s4_sod    <= {s3_r, s3_lo};
      s4_era    <= era_p;
      s4_yoe    <= yoe_diff[8:0];
      s4_doy    <= month_start(s3_mp) + 9'(s3_d) - 9'd1;
      s4_packed <= s3_packed;
    end
  end

  assign yq_prod = 19'(s4_yoe) * 19'(RCP_100Y);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_zs     <= s4_zs;
      s5_sod    <= s4_sod;
      s5_era    <= s4_era;
      s5_doe    <= (18'(s4_yoe) * 18'd365) + 18'(s4_yoe[8:2]) - 18'(yq_prod[17:16])
                   + 18'(s4_doy);
      s5_packed <= s4_packed;
    end
  end

  assign zp = (21'(s5_era) * DAYS_PER_ERA) + 21'(s5_doe);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      front.z           <= s5_packed ? zp : s5_zs;
      front.sod         <= s5_packed ? '0 : s5_sod;
      front.packed_date <= s5_packed;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tsc_civil.sv
`default_nettype none

module tsc_civil (
  input  logic                             clk,
  input  logic [tsc_pkg::BACK_STAGES-1:0]  en,
  input  logic [tsc_pkg::Z_W-1:0]          z,
  output logic [tsc_pkg::YEAR_W-1:0]       year,
  output logic [tsc_pkg::MONTH_W-1:0]      month,
  output logic [tsc_pkg::DAY_W-1:0]        day
);
  import tsc_pkg::*;

  logic [ERA_W-1:0]  c1_era, c2_era, c3_era, c4_era, c5_era, c6_era;
  logic [Z_W-1:0]    c1_z;
  logic [DOE_W-1:0]  c2_doe, c3_doe, c4_doe, c5_doe, c6_doe;
  logic [6:0]        c3_da;
  logic [2:0]        c3_db;
  logic              c3_dc;
  logic [DOE_W-1:0]  c4_t;
  logic [YOE_W-1:0]  c5_yoe, c6_yoe;
  logic [1:0]        c6_yh;
  logic [DOY_W-1:0]  c7_doy, c8_doy;
  logic [YEAR_W-1:0] c7_yr, c8_yr;
  logic [3:0]        c8_mp;

  logic [42:0]       era_prod;
  logic [Z_W-1:0]    doe_diff;
  logic [35:0]       da_prod;
  logic [35:0]       db_prod;
  logic [35:0]       yoe_prod;
  logic [18:0]       yh_prod;
  logic [DOE_W-1:0]  doy_diff;
  logic [10:0]       mp_arg;
  logic [22:0]       mp_prod;
  logic [DOY_W-1:0]  day_diff;

  assign era_prod = 43'(z) * 43'(RCP_ERA);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c1_era <= era_prod[41:39];
      c1_z   <= z;
    end
  end

  assign doe_diff = c1_z - (21'(c1_era) * DAYS_PER_ERA);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c2_doe <= doe_diff[DOE_W-1:0];
      c2_era <= c1_era;
    end
  end

  assign da_prod = 36'(c2_doe) * 36'(RCP_1460);
  assign db_prod = 36'(c2_doe) * 36'(RCP_36524);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c3_da  <= da_prod[34:28];
      c3_db  <= db_prod[35:33];
      c3_dc  <= (c2_doe == 18'd146096);
      c3_doe <= c2_doe;
      c3_era <= c2_era;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      c4_t   <= c3_doe - 18'(c3_da) + 18'(c3_db) - 18'(c3_dc);
      c4_doe <= c3_doe;
      c4_era <= c3_era;
    end
  end

  assign yoe_prod = 36'(c4_t) * 36'(RCP_365);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c5_yoe <= yoe_prod[34:26];
      c5_doe <= c4_doe;
      c5_era <= c4_era;
    end
  end

  assign yh_prod = 19'(c5_yoe) * 19'(RCP_100Y);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      c6_yh  <= yh_prod[17:16];
      c6_yoe <= c5_yoe;
      c6_doe <= c5_doe;
      c6_era <= c5_era;
    end
  end

  assign doy_diff = c6_doe - ((18'(c6_yoe) * 18'd365) + 18'(c6_yoe[8:2]) - 18'(c6_yh));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      c7_doy <= doy_diff[DOY_W-1:0];
      c7_yr  <= (12'(c6_era) * 12'd400) + 12'(c6_yoe);
    end
  end

  assign mp_arg  = (11'(c7_doy) * 11'd5) + 11'd2;
  assign mp_prod = 23'(mp_arg) * 23'(RCP_153);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      c8_mp  <= mp_prod[22:19];
      c8_doy <= c7_doy;
      c8_yr  <= c7_yr;
    end
  end

  assign day_diff = c8_doy - month_start(c8_mp) + 9'd1;

  // shifted months 10 and 11 are January and February of the next year
  always_ff @(posedge clk) begin
    if (en[8]) begin
      day   <= day_diff[DAY_W-1:0];
      month <= (c8_mp < 4'd10) ? c8_mp + 4'd3 : c8_mp - 4'd9;
      year  <= (c8_mp >= 4'd10) ? c8_yr + 12'd1 : c8_yr;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tsc_tod.sv
`default_nettype none

module tsc_tod (
  input  logic                            clk,
  input  logic [tsc_pkg::BACK_STAGES-1:0] en,
  input  logic [tsc_pkg::SOD_W-1:0]       sod,
  input  logic                            packed_date,
  output logic [tsc_pkg::HOUR_W-1:0]      hour,
  output logic [tsc_pkg::MIN_W-1:0]       minute,
  output logic [tsc_pkg::SEC_W-1:0]       second,
  output logic                            packed_date_seen
);
  import tsc_pkg::*;

  localparam int CARRY = BACK_STAGES - 3;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              packed_date;
  } tod_t;

  logic [SOD_W-1:0]  t1_sod;
  logic [HOUR_W-1:0] t1_hour, t2_hour, t3_hour;
  logic              t1_pd, t2_pd, t3_pd;
  logic [11:0]       t2_rem, t3_rem;
  logic [MIN_W-1:0]  t3_min;
  tod_t              carry [CARRY];

  logic [34:0]       hour_prod;
  logic [SOD_W-1:0]  rem_diff;
  logic [24:0]       min_prod;
  logic [11:0]       sec_diff;

  assign hour_prod = 35'(sod) * 35'(RCP_3600);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1_hour <= hour_prod[33:29];
      t1_sod  <= sod;
      t1_pd   <= packed_date;
    end
  end

  assign rem_diff = t1_sod - (17'(t1_hour) * 17'd3600);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t2_rem  <= rem_diff[11:0];
      t2_hour <= t1_hour;
      t2_pd   <= t1_pd;
    end
  end

  assign min_prod = 25'(t2_rem) * 25'(RCP_60);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t3_min  <= min_prod[23:18];
      t3_rem  <= t2_rem;
      t3_hour <= t2_hour;
      t3_pd   <= t2_pd;
    end
  end

  assign sec_diff = t3_rem - (12'(t3_min) * 12'd60);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      carry[0] <= '{hour: t3_hour, minute: t3_min, second: sec_diff[SEC_W-1:0],
                    packed_date: t3_pd};
    end
    for (int i = 1; i < CARRY; i++) begin
      if (en[3+i]) begin
        carry[i] <= carry[i-1];
      end
    end
  end

  assign hour             = carry[CARRY-1].hour;
  assign minute           = carry[CARRY-1].minute;
  assign second           = carry[CARRY-1].second;
  assign packed_date_seen = carry[CARRY-1].packed_date;

endmodule

`default_nettype wire

// File: rtl/timestamp_to_calendar.sv
// An accepted request reaches its result on cal through 6 front stages
// (seconds split, packed date decode) and 9 back stages (date from day number,
// time of day). Throughput: one request per cycle while cal.ready is high.
// A stall on cal.ready holds only the full stages; empty stages still fill.
// Reset (rst, synchronous) clears the stage valid bits; data is not reset.
`default_nettype none

module timestamp_to_calendar (
  input  logic      clk,
  input  logic      rst,
  tsc_in_if.sink    stamp,
  tsc_out_if.source cal
);
  import tsc_pkg::*;

  logic [STAGES-1:0] en;
  front_t            front;

  tsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stamp.valid),
    .out_ready (cal.ready),
    .in_ready  (stamp.ready),
    .out_valid (cal.valid),
    .en        (en)
  );

  tsc_front u_front (
    .clk         (clk),
    .en          (en[FRONT_STAGES-1:0]),
    .stamp_value (stamp.stamp_value),
    .front       (front)
  );

  tsc_civil u_civil (
    .clk   (clk),
    .en    (en[STAGES-1:FRONT_STAGES]),
    .z     (front.z),
    .year  (cal.year),
    .month (cal.month),
    .day   (cal.day)
  );

  tsc_tod u_tod (
    .clk              (clk),
    .en               (en[STAGES-1:FRONT_STAGES]),
    .sod              (front.sod),
    .packed_date      (front.packed_date),
    .hour             (cal.hour),
    .minute           (cal.minute),
    .second           (cal.second),
    .packed_date_seen (cal.packed_date_seen)
  );

endmodule

`default_nettype wire

// File: rtl/tsc_checker.sv
`default_nettype none

module tsc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tsc_pkg::YEAR_W-1:0]   year,
  input logic [tsc_pkg::MONTH_W-1:0]  month,
  input logic [tsc_pkg::DAY_W-1:0]    day,
  input logic [tsc_pkg::HOUR_W-1:0]   hour,
  input logic [tsc_pkg::MIN_W-1:0]    minute,
  input logic [tsc_pkg::SEC_W-1:0]    second,
  input logic                         packed_date_seen
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
      && $stable(day) && $stable(hour) && $stable(minute) && $stable(second)
      && $stable(packed_date_seen))
    else $error("stalled result changed");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("request blocked while output drains");

  a_midnight: assert property (@(posedge clk) disable iff (rst)
    out_valid && packed_date_seen |-> hour == '0 && minute == '0 && second == '0)
    else $error("packed date result not at midnight");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31
      && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("calendar field out of range");

endmodule

bind timestamp_to_calendar tsc_checker u_tsc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (stamp.ready),
  .out_valid        (cal.valid),
  .out_ready        (cal.ready),
  .year             (cal.year),
  .month            (cal.month),
  .day              (cal.day),
  .hour             (cal.hour),
  .minute           (cal.minute),
  .second           (cal.second),
  .packed_date_seen (cal.packed_date_seen)
);

`default_nettype wire

// File: tb/timestamp_to_calendar_tb.sv
`default_nettype none

module timestamp_to_calendar_tb;
  import tsc_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int ITEMS_PER_PASS = 390;
  localparam int N_DIR          = 21;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               packed_date_seen;
  } cal_t;

  typedef struct {
    logic signed [STAMP_W-1:0] stamp;
    cal_t                      cal;
  } due_t;

  typedef struct {
    logic signed [STAMP_W-1:0] stamp;
    bit                        typed;
    cal_t                      cal;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsc_in_if  stamp_if ();
  tsc_out_if cal_if ();

  timestamp_to_calendar u_dut (
    .clk  (clk),
    .rst  (rst),
    .stamp(stamp_if),
    .cal  (cal_if)
  );

  always #5 clk = ~clk;

  due_t   cal_due [$];
  int     mismatches  = 0;
  int     cycle_count = 0;
  int     idle_pct    = 0;
  int     stall_pct   = 0;

  const string field_name [7] = '{"year", "month", "day", "hour", "minute", "second",
                                  "packed_date_seen"};

  // typed rows: hand values; the rest go through the predictor
  dir_row_t dir_rows [N_DIR] = '{
    '{36'sd0,            1'b1, '{1970, 1, 1, 0, 0, 0, 0}},
    '{-36'sd1,           1'b1, '{1969, 12, 31, 23, 59, 59, 0}},
    '{36'sd86399,        1'b1, '{1970, 1, 1, 23, 59, 59, 0}},
    '{36'sd86400,        1'b1, '{1970, 1, 2, 0, 0, 0, 0}},
    '{-36'sd86400,       1'b1, '{1969, 12, 31, 0, 0, 0, 0}},
    '{-36'sd86401,       1'b1, '{1969, 12, 30, 23, 59, 59, 0}},
    '{36'sh7FFFFFFFF,    1'b0, '{0, 0, 0, 0, 0, 0, 0}},
    '{36'sh800000000,    1'b0, '{0, 0, 0, 0, 0, 0, 0}},
    '{36'sd19000101,     1'b1, '{1900, 1, 1, 0, 0, 0, 1}},
    '{36'sd29991231,     1'b1, '{2999, 12, 31, 0, 0, 0, 1}},
    '{36'sd19700101,     1'b1, '{1970, 1, 1, 0, 0, 0, 1}},
    '{36'sd20230231,     1'b1, '{2023, 3, 3, 0, 0, 0, 1}},
    '{36'sd20230431,     1'b1, '{2023, 5, 1, 0, 0, 0, 1}},
    '{36'sd20240229,     1'b1, '{2024, 2, 29, 0, 0, 0, 1}},
    '{36'sd21000229,     1'b1, '{2100, 3, 1, 0, 0, 0, 1}},
    '{36'sd20000229,     1'b1, '{2000, 2, 29, 0, 0, 0, 1}},
    '{36'sd19000100,     1'b0, '{0, 0, 0, 0, 0, 0, 0}},
    '{36'sd29991232,     1'b0, '{0, 0, 0, 0, 0, 0, 0}},
    '{36'sd19001301,     1'b0, '{0, 0, 0, 0, 0, 0, 0}},
    '{36'sd19000132,     1'b0, '{0, 0, 0, 0, 0, 0, 0}},
    '{36'sd19991200,     1'b0, '{0, 0, 0, 0, 0, 0, 0}}
  };

  function automatic cal_t civil_of_stamp(input logic signed [STAMP_W-1:0] v);
    longint s, days, sod, z, era, doe, yoe, doy, mp, yy, y, m, d, pm, pd;
    bit     is_packed;
    cal_t   r;
    s  = v;
    pm = (s / 100) % 100;
    pd = s % 100;
    is_packed = s >= 19000101 && s <= 29991231 && pm >= 1 && pm <= 12 && pd >= 1 && pd <= 31;
    if (is_packed) begin
      yy = s / 10000;
      if (pm <= 2) yy = yy - 1;
      era = yy / 400;
      yoe = yy - era * 400;
      doy = (153 * (pm > 2 ? pm - 3 : pm + 9) + 2) / 5 + pd - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      s   = (era * 146097 + doe - 719468) * 86400;
    end
    days = s / 86400;
    sod  = s % 86400;
    if (sod < 0) begin
      sod  = sod + 86400;
      days = days - 1;
    end
    z   = days + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yy  = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = mp < 10 ? mp + 3 : mp - 9;
    y   = yy + (m <= 2 ? 1 : 0);
    r.year             = YEAR_W'(y);
    r.month            = MONTH_W'(m);
    r.day              = DAY_W'(d);
    r.hour             = HOUR_W'(sod / 3600);
    r.minute           = MIN_W'((sod % 3600) / 60);
    r.second           = SEC_W'(sod % 60);
    r.packed_date_seen = is_packed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [STAMP_W-1:0] stamp,
                                 input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch: %s stamp=%0d got=%0d want=%0d", what, stamp, got, want);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic signed [STAMP_W-1:0] v, input cal_t want);
    while ($urandom_range(99) < idle_pct) begin
      stamp_if.valid <= 1'b0;
      @(negedge clk);
    end
    stamp_if.valid       <= 1'b1;
    stamp_if.stamp_value <= v;
    do @(posedge clk); while (!stamp_if.ready);
    cal_due.insert(cal_due.size(), due_t'{v, want});
    @(negedge clk);
  endtask

  task automatic drain_results();
    stamp_if.valid <= 1'b0;
    while (cal_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  always @(negedge clk) begin
    cal_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    due_t   head;
    longint got [7];
    longint want [7];
    if (!rst && cal_if.valid && cal_if.ready) begin
      if (cal_due.size() == 0) begin
        report_mismatch("request with nothing due", '0, cal_if.year, 0);
      end else begin
        head = cal_due.pop_front();
        got  = '{cal_if.year, cal_if.month, cal_if.day, cal_if.hour, cal_if.minute,
                 cal_if.second, cal_if.packed_date_seen};
        want = '{head.cal.year, head.cal.month, head.cal.day, head.cal.hour,
                 head.cal.minute, head.cal.second, head.cal.packed_date_seen};
        for (int k = 0; k < 7; k++)
          if (got[k] != want[k]) report_mismatch(field_name[k], head.stamp, got[k], want[k]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out with %0d results due", cal_due.size());
      $display("timestamp_to_calendar regression: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0]               bits;
    logic signed [STAMP_W-1:0] v;
    longint                    s;
    cal_t                      want;
    stamp_if.valid       = 1'b0;
    stamp_if.stamp_value = '0;
    cal_if.ready         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      want = dir_rows[i].typed ? dir_rows[i].cal : civil_of_stamp(dir_rows[i].stamp);
      send_request(dir_rows[i].stamp, want);
    end
    drain_results();

    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int i = 0; i < ITEMS_PER_PASS; i++) begin
        bits = {$urandom(), $urandom()};
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // packed date candidates, leaning on month ends and bad digits
            s = longint'($urandom_range(3000, 1899)) * 10000 +
                longint'($urandom_range(13, 0)) * 100 +
                ($urandom_range(1) ? $urandom_range(32, 27) : $urandom_range(32, 0));
            v = STAMP_W'(s);
          end
          4, 5, 6: v = bits[STAMP_W-1:0];
          7: begin
            // near day boundaries around the epoch
            s = longint'($urandom_range(20000)) * 86400 + $urandom_range(2) - 1;
            v = STAMP_W'($urandom_range(1) ? -s : s);
          end
          8: v = STAMP_W'(longint'(36'sh7FFFFFFFF) - $urandom_range(400000));
          default: v = STAMP_W'(longint'(36'sh800000000) + $urandom_range(400000));
        endcase
        send_request(v, civil_of_stamp(v));
        if (pass == 1 && i == ITEMS_PER_PASS / 2) drain_results();
      end
      drain_results();
    end

    stall_pct = 0;
    while (cal_due.size() != 0) @(posedge clk);
    repeat (STAGES + 25) @(posedge clk);
    if (mismatches == 0) begin
      $display("timestamp_to_calendar regression: pass");
    end else begin
      $display("timestamp_to_calendar regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
